// ===== sv/bdb_pkg.sv =====
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types and constants for the B-spline de Boor evaluator.
// ----------------------------------------------------------------------------
package bdb_pkg;

    localparam int DEGREE_DEF         = 3;
    localparam int INTERNAL_KNOTS_DEF = 16;
    localparam int DW                 = 32;   // Q16.16 data width
    localparam int AQ                 = 30;   // alpha fraction bits (Q1.30)

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_COEF   = 2'd2,
        OP_EVAL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOTREADY = 2'd2
    } t_status;

    // divider request: start pulse with positive numerator < denominator
    typedef struct packed {
        logic          start;
        logic [DW:0]   num;
        logic [DW:0]   den;
    } t_div_req;

endpackage

// ===== sv/bspline_de_boor_evaluator.sv =====
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator
// Clamped B-spline evaluator, signed Q16.16, de Boor recursion.
// ----------------------------------------------------------------------------
// One request at a time. Clear and coefficient writes finish in the idle state.
// An insert walks down from the top of the stored breakpoints, moving each
// larger one up a slot: read, compare, write back through the breakpoint
// memory (one write port, one registered read port). An evaluation reads the
// end breakpoints for a range check, searches the span, loads the coefficients,
// then runs DEGREE*(DEGREE+1)/2 blend steps with rotate steps between passes;
// a blend step waits on the one-bit-per-cycle alpha divider only when the point
// lies strictly inside the knot interval. A status-1 evaluation ends after the
// range check, a status-2 evaluation goes straight to the output. A finished result
// waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module bspline_de_boor_evaluator
    import bdb_pkg::*;
#(
    parameter int DEGREE         = DEGREE_DEF,
    parameter int INTERNAL_KNOTS = INTERNAL_KNOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [4:0]         i_coeff_index,
    input  logic signed [31:0] i_operand_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_spline_value,
    output logic [1:0]         o_status
);

    localparam int NUM_BP   = INTERNAL_KNOTS + 2;
    localparam int NUM_COEF = INTERNAL_KNOTS + DEGREE + 1;
    localparam int BW       = $clog2(NUM_BP);
    localparam int CW       = $clog2(NUM_BP + 1);
    localparam int CAW      = $clog2(NUM_COEF);
    localparam int DGW      = $clog2(DEGREE + 2);
    localparam logic [AQ:0] ALPHA_ONE = {1'b1, {AQ{1'b0}}};
    localparam logic [65:0] RND_HALF  = 66'(1) << (AQ - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_EV_A, S_EV_B, S_EV_C, S_SRCH,
        S_CLD, S_K0, S_K1, S_K2, S_DIV, S_MUL, S_BLEND, S_ROT, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_v;
    logic [BW-1:0]      r_p;
    logic [CW-1:0]      r_cnt;
    logic signed [31:0] r_lo;
    logic [BW-1:0]      r_sa;
    logic [BW-1:0]      r_sq;
    logic               r_sv;
    logic [BW-1:0]      r_s;
    logic [DGW-1:0]     r_cm;
    logic [DGW-1:0]     r_cmq;
    logic               r_cv;
    logic [DGW-1:0]     r_j;
    logic [DGW-1:0]     r_m;
    logic [DGW-1:0]     r_rot;
    logic signed [31:0] r_d [0:DEGREE];
    logic [AQ:0]        r_a;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_res;
    t_status            r_st;
    logic               r_ovalid;
    logic signed [31:0] r_oval;
    t_status            r_ost;

    logic               w_bp_we;
    logic [BW-1:0]      w_bp_waddr;
    logic signed [31:0] w_bp_wdata;
    logic [BW-1:0]      w_bp_raddr;
    logic signed [31:0] w_bp_rd;
    logic               w_cf_we;
    logic [CAW-1:0]     w_cf_raddr;
    logic signed [31:0] w_cf_rd;
    int                 w_i;
    int                 w_k;
    logic signed [32:0] w_num;
    logic signed [32:0] w_den;
    logic               w_a_zero;
    logic               w_a_one;
    t_div_req           w_div_req;
    logic               w_div_done;
    logic [AQ:0]        w_quot;
    logic signed [32:0] w_diff;
    logic signed [63:0] w_prod;
    logic [65:0]        w_sum;
    logic [35:0]        w_bl;
    logic signed [31:0] w_blend;

    // clamped knot vector index -> breakpoint address
    function automatic logic [BW-1:0] f_kidx(input int j);
        if (j <= DEGREE) begin
            return '0;
        end else if (j >= DEGREE + INTERNAL_KNOTS + 1) begin
            return BW'(NUM_BP - 1);
        end else begin
            return BW'(j - DEGREE);
        end
    endfunction

    assign o_stall = (r_state != S_IDLE);

    assign w_i = int'(r_m) + int'(r_s);
    assign w_k = DEGREE + 1 - int'(r_j);

    // breakpoint memory ports
    always_comb begin
        w_bp_we    = 1'b0;
        w_bp_waddr = r_p;
        w_bp_wdata = r_v;
        case (r_state)
            S_INS_RD:  w_bp_raddr = r_p - 1'b1;
            S_EV_A:    w_bp_raddr = '0;
            S_EV_B:    w_bp_raddr = BW'(NUM_BP - 1);
            S_SRCH:    w_bp_raddr = r_sa;
            S_K0:      w_bp_raddr = f_kidx(w_i);
            S_K1:      w_bp_raddr = f_kidx(w_i + w_k);
            default:   w_bp_raddr = '0;
        endcase
        if (r_state == S_INS_RD && r_p == '0) begin
            w_bp_we = 1'b1;
        end
        if (r_state == S_INS_CMP) begin
            w_bp_we = 1'b1;
            if (w_bp_rd > r_v) begin
                w_bp_wdata = w_bp_rd;
            end
        end
    end

    assign w_cf_we    = (r_state == S_IDLE) && i_valid && (t_op'(i_op) == OP_COEF)
                      && (32'(i_coeff_index) < NUM_COEF);
    assign w_cf_raddr = CAW'(int'(r_s) + int'(r_cm));

    // alpha operands: lo knot in r_lo, hi knot on the read port
    assign w_num    = {r_v[31], r_v} - {r_lo[31], r_lo};
    assign w_den    = {w_bp_rd[31], w_bp_rd} - {r_lo[31], r_lo};
    assign w_a_zero = (w_den <= 0) || (w_num <= 0);
    assign w_a_one  = (w_num >= w_den);

    assign w_div_req.start = (r_state == S_K2) && !w_a_zero && !w_a_one;
    assign w_div_req.num   = w_num;
    assign w_div_req.den   = w_den;

    // blend: lo*2^30 + alpha*(hi - lo), rounded, arithmetic shift by 30
    assign w_diff = {r_d[DEGREE][31], r_d[DEGREE]} - {r_d[DEGREE-1][31], r_d[DEGREE-1]};
    assign w_prod = $signed({1'b0, r_a}) * w_diff;
    assign w_sum  = {{4{r_d[DEGREE-1][31]}}, r_d[DEGREE-1], {AQ{1'b0}}}
                  + {{2{r_prod[63]}}, r_prod} + RND_HALF;
    assign w_bl   = w_sum[65:AQ];

    always_comb begin
        if (w_bl[35:31] == {5{w_bl[31]}}) begin
            w_blend = w_bl[31:0];
        end else if (w_bl[35]) begin
            w_blend = 32'sh8000_0000;
        end else begin
            w_blend = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_sv     <= 1'b0;
            r_cv     <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_v <= i_operand_value;
                        case (t_op'(i_op))
                            OP_CLEAR: begin
                                r_cnt <= '0;
                            end
                            OP_INSERT: begin
                                if (r_cnt < CW'(NUM_BP)) begin
                                    r_p     <= BW'(r_cnt);
                                    r_state <= S_INS_RD;
                                end
                            end
                            OP_EVAL: begin
                                if (r_cnt < CW'(NUM_BP)) begin
                                    r_res   <= '0;
                                    r_st    <= ST_NOTREADY;
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_EV_A;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_p == '0) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_INS_CMP;
                    end
                end
                S_INS_CMP: begin
                    // larger neighbor moved up one slot; otherwise value lands here
                    if (w_bp_rd > r_v) begin
                        r_p     <= r_p - 1'b1;
                        r_state <= S_INS_RD;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EV_A: begin
                    r_state <= S_EV_B;
                end
                S_EV_B: begin
                    r_lo    <= w_bp_rd;
                    r_state <= S_EV_C;
                end
                S_EV_C: begin
                    if (r_v < r_lo || r_v > w_bp_rd) begin
                        r_res   <= '0;
                        r_st    <= ST_RANGE;
                        r_state <= S_OUT;
                    end else begin
                        r_sa    <= BW'(1);
                        r_sv    <= 1'b0;
                        r_state <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    // one read issued per cycle, compared in the cycle after
                    r_sq <= r_sa;
                    r_sv <= 1'b1;
                    if (r_sa < BW'(INTERNAL_KNOTS + 1)) begin
                        r_sa <= r_sa + 1'b1;
                    end
                    if (r_sv && (r_v < w_bp_rd || r_sq == BW'(INTERNAL_KNOTS))) begin
                        r_s     <= (r_v < w_bp_rd) ? r_sq - 1'b1 : r_sq;
                        r_sv    <= 1'b0;
                        r_cm    <= '0;
                        r_cv    <= 1'b0;
                        r_state <= S_CLD;
                    end
                end
                S_CLD: begin
                    r_cv  <= (r_cm <= DGW'(DEGREE));
                    r_cmq <= r_cm;
                    if (r_cm <= DGW'(DEGREE)) begin
                        r_cm <= r_cm + 1'b1;
                    end
                    if (r_cv) begin
                        for (int k = 0; k < DEGREE; k++) begin
                            r_d[k] <= r_d[k+1];
                        end
                        r_d[DEGREE] <= w_cf_rd;
                        if (r_cmq == DGW'(DEGREE)) begin
                            r_cv    <= 1'b0;
                            r_j     <= DGW'(1);
                            r_m     <= DGW'(DEGREE);
                            r_state <= S_K0;
                        end
                    end
                end
                S_K0: begin
                    r_state <= S_K1;
                end
                S_K1: begin
                    r_lo    <= w_bp_rd;
                    r_state <= S_K2;
                end
                S_K2: begin
                    if (w_a_zero) begin
                        r_a     <= '0;
                        r_state <= S_MUL;
                    end else if (w_a_one) begin
                        r_a     <= ALPHA_ONE;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_a     <= w_quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    if (r_j == DGW'(DEGREE)) begin
                        r_res   <= w_blend;
                        r_st    <= ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        // rotate so the next pair sits in the top two slots
                        for (int k = 1; k <= DEGREE; k++) begin
                            r_d[k] <= r_d[k-1];
                        end
                        r_d[0] <= w_blend;
                        if (r_m == r_j) begin
                            r_rot   <= r_j;
                            r_state <= S_ROT;
                        end else begin
                            r_m     <= r_m - 1'b1;
                            r_state <= S_K0;
                        end
                    end
                end
                S_ROT: begin
                    // finish a full turn to realign slots with d[] indexes
                    for (int k = 1; k <= DEGREE; k++) begin
                        r_d[k] <= r_d[k-1];
                    end
                    r_d[0] <= r_d[DEGREE];
                    if (r_rot == DGW'(1)) begin
                        r_j     <= r_j + 1'b1;
                        r_m     <= DGW'(DEGREE);
                        r_state <= S_K0;
                    end else begin
                        r_rot <= r_rot - 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_oval   <= r_res;
                        r_ost    <= r_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_spline_value = r_oval;
    assign o_status       = r_ost;

    bdb_bp_mem #(
        .DEPTH (NUM_BP)
    ) u_bp_mem (
        .i_clk   (i_clk),
        .i_we    (w_bp_we),
        .i_waddr (w_bp_waddr),
        .i_wdata (w_bp_wdata),
        .i_raddr (w_bp_raddr),
        .o_rdata (w_bp_rd)
    );

    bdb_coef_mem #(
        .DEPTH (NUM_COEF)
    ) u_coef_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_cf_we),
        .i_waddr (CAW'(i_coeff_index)),
        .i_wdata (i_operand_value),
        .i_raddr (w_cf_raddr),
        .o_rdata (w_cf_rd)
    );

    bdb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

endmodule

// ===== sv/bdb_bp_mem.sv =====
// ----------------------------------------------------------------------------
// bdb_bp_mem
// Breakpoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bdb_bp_mem #(
    parameter  int DEPTH = 18,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [31:0]   o_rdata
);

    logic signed [31:0] r_mem [0:DEPTH-1];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/bdb_coef_mem.sv =====
// ----------------------------------------------------------------------------
// bdb_coef_mem
// Coefficient store with per-entry valid bits; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bdb_coef_mem #(
    parameter  int DEPTH = 20,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [31:0]   i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [31:0]   o_rdata
);

    logic signed [31:0] r_mem [0:DEPTH-1];
    logic signed [31:0] r_rdata;
    logic [DEPTH-1:0]   r_vld;
    logic               r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== sv/bdb_div.sv =====
// ----------------------------------------------------------------------------
// bdb_div
// Radix-2 restoring divider for alpha: round((num << 30) / den), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdb_div
    import bdb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [AQ:0] o_quot
);

    localparam int QB  = AQ + 1;               // quotient bits
    localparam int DVW = DW + 1 + AQ + 1;      // dividend width
    localparam int CNW = $clog2(QB + 1);

    logic [DVW-1:0] w_dvd;
    logic [DW+1:0]  w_sh;
    logic           w_ge;
    logic [DW+1:0]  w_rem_nx;

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW+1:0]  r_rem;
    logic [QB-1:0]  r_lo;
    logic [QB-1:0]  r_q;
    logic [DW:0]    r_den;

    // half the divisor added up front gives round-half-up
    assign w_dvd    = {1'b0, i_req.num, {AQ{1'b0}}}
                    + {{(DVW-DW){1'b0}}, i_req.den[DW:1]};
    assign w_sh     = {r_rem[DW:0], r_lo[QB-1]};
    assign w_ge     = (w_sh >= {1'b0, r_den});
    assign w_rem_nx = w_ge ? (w_sh - {1'b0, r_den}) : w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, w_dvd[DVW-1:QB]};
                r_lo   <= w_dvd[QB-1:0];
                r_den  <= i_req.den;
                r_cnt  <= CNW'(QB);
            end else if (r_busy) begin
                r_rem <= w_rem_nx;
                r_lo  <= {r_lo[QB-2:0], 1'b0};
                r_q   <= {r_q[QB-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== sv/bdb_checker.sv =====
// ----------------------------------------------------------------------------
// bdb_checker
// Port-level checks for the B-spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bdb_checker
    import bdb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [1:0]         i_op,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_spline_value,
    input logic [1:0]         o_status
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_spline_value) && $stable(o_status))
        else $error("result changed while stalled");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_spline_value == 32'sd0)
        else $error("nonzero value with error status");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    // a clear request with nothing pending creates no result
    a_clear_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_op == OP_CLEAR && !o_valid |=> !o_valid)
        else $error("result appeared after clear request");

endmodule

bind bspline_de_boor_evaluator bdb_checker u_bdb_checker (.*);
